@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the serial-bus frame decoder
// Frame layout, link status codes and the frame record passed from the
// byte collector to the channel emitter.
// ----------------------------------------------------------------------------
package sfd_pkg;

	// frame layout
	localparam int CHANNELS     = 16;
	localparam int CHAN_W       = $clog2(CHANNELS);
	localparam int VALUE_W      = 11;
	localparam int DATA_BYTES   = 22;
	localparam int STORED_BYTES = DATA_BYTES + 1;
	localparam int DATA_W       = DATA_BYTES * 8;
	localparam int STORE_W      = STORED_BYTES * 8;
	localparam int POS_W        = 5;
	localparam int BASE_W       = $clog2(DATA_W);

	localparam logic [7:0] START_BYTE   = 8'h0f;
	localparam logic [7:0] END_BYTE     = 8'h00;
	localparam int         LOST_BIT     = 2;
	localparam int         FAILSAFE_BIT = 3;

	// queue between collector and emitter
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// output item packing
	localparam int OUT_FIELDS_W = CHAN_W + VALUE_W + 2;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		LINK_OK       = 2'd0,
		LINK_LOST     = 2'd1,
		LINK_FAILSAFE = 2'd2
	} link_status_t;

	// one complete, checked frame
	typedef struct packed {
		link_status_t      status;
		logic [DATA_W-1:0] data;
	} frame_t;

	// queue handshake between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic link_status_t decode_flags(input logic [7:0] flags);
		link_status_t s;
		if (flags[FAILSAFE_BIT]) begin
			s = LINK_FAILSAFE;
		end else if (flags[LOST_BIT]) begin
			s = LINK_LOST;
		end else begin
			s = LINK_OK;
		end
		return s;
	endfunction

endpackage

@@ rtl/sbus_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// sbus_frame_decoder_top: serial-bus frame decoder, 16 proportional channels
// Collects 25-byte frames from a byte stream and emits one item per channel.
//
//   channel  dir  tdata bits (low first)                         tlast
//   s_*      in   [7:0] rx_byte                                   -
//   m_*      out  [3:0] channel_index, [14:4] channel_value,      last
//                 [16:15] link_status, [23:17] zero
//
// Each input byte is accepted while s_tready is high; a good end byte hands the frame to
// a two-entry queue, and the emitter loads it from the queue and then sends its 16 items,
// one per cycle while m_tready allows, from its output register.
// s_tready drops only on an end byte while the queue holds two frames.
// Reset returns the collector to hunting and empties queue and emitter.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_top import sfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] rx_byte
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [3:0] channel_index, [14:4] channel_value,
	                                          // [16:15] link_status, rest zero
	output logic                   m_tlast    // last
);

	q_status_t q_stat;
	logic      push;
	frame_t    push_frame;
	logic      pop;
	frame_t    pop_frame;

	sfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	sfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.q_stat     (q_stat)
	);

	sfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_frame (pop_frame),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ rtl/sfd_front.sv @@
// ----------------------------------------------------------------------------
// sfd_front: byte collector
// Hunts for the start byte, shifts the 23 frame bytes into a shift line and,
// on a good end byte, pushes the frame and its link status into the queue.
// ----------------------------------------------------------------------------
module sfd_front import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [7:0] rx_byte
	input  q_status_t  q_stat,
	output logic       push,
	output frame_t     push_frame
);

	logic              in_frame_q;
	logic [POS_W-1:0]  pos_q;
	logic [STORE_W-1:0] bytes_q;
	logic              at_end;
	logic              take;

	// end-byte slot: position 23 or beyond
	assign at_end   = in_frame_q && (pos_q >= POS_W'(STORED_BYTES));
	assign s_tready = !(at_end && q_stat.full);
	assign take     = s_tvalid && s_tready;

	// frame push on a good end byte
	assign push              = take && at_end && (s_tdata == END_BYTE);
	assign push_frame.data   = bytes_q[DATA_W-1:0];
	assign push_frame.status = decode_flags(bytes_q[STORE_W-1 -: 8]);

	// frame position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
		end else if (take) begin
			if (!in_frame_q) begin
				if (s_tdata == START_BYTE) begin
					in_frame_q <= 1'b1;
					pos_q      <= '0;
				end
			end else if (at_end) begin
				in_frame_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// shift line: first data byte ends up in the low bits
	always_ff @(posedge clk) begin
		if (take && in_frame_q && !at_end) begin
			bytes_q <= {s_tdata, bytes_q[STORE_W-1:8]};
		end
	end

endmodule

@@ rtl/sfd_queue.sv @@
// ----------------------------------------------------------------------------
// sfd_queue: short frame queue
// Holds checked frames between the collector and the emitter.
// ----------------------------------------------------------------------------
module sfd_queue import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  frame_t    push_frame,
	input  logic      pop,
	output frame_t    pop_frame,
	output q_status_t q_stat
);

	frame_t            entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign pop_frame    = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

@@ rtl/sfd_back.sv @@
// ----------------------------------------------------------------------------
// sfd_back: channel emitter
// Takes one frame from the queue and emits its 16 channel items, one per
// cycle while the receiver accepts them, through an output register.
// ----------------------------------------------------------------------------
module sfd_back import sfd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_status_t              q_stat,
	input  frame_t                 pop_frame,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [3:0] channel_index, [14:4] channel_value,
	                                         // [16:15] link_status, rest zero
	output logic                   m_tlast   // last
);

	logic [DATA_W-1:0] frame_q;
	link_status_t      status_q;
	logic              busy_q;
	logic [CHAN_W-1:0] chan_q;
	logic              out_valid_q;
	logic [OUT_FIELDS_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_free;
	logic              emit;
	logic [BASE_W-1:0] base;
	logic [VALUE_W-1:0] value;

	assign out_free = !out_valid_q || m_tready;
	assign emit     = busy_q && out_free;
	assign pop      = !busy_q && !q_stat.empty;

	// channel c sits at bits 11*c .. 11*c+10
	assign base  = BASE_W'(chan_q) * BASE_W'(VALUE_W);
	assign value = frame_q[base +: VALUE_W];

	// frame load and channel sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			chan_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			chan_q <= '0;
		end else if (emit) begin
			chan_q <= chan_q + 1'b1;
			if (chan_q == CHAN_W'(CHANNELS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q  <= pop_frame.data;
			status_q <= pop_frame.status;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= {status_q, value, chan_q};
			out_last_q <= (chan_q == CHAN_W'(CHANNELS - 1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_data_q);
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks of the frame decoder
// Watches the output channel for stalls, frame end and field ranges.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// the frame ends on the final channel and only there
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[CHAN_W-1:0] == CHAN_W'(CHANNELS - 1))))
		else $error("tlast does not match final channel");

	// link status is one of the three codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_FIELDS_W-1 -: 2] != 2'b11)
		else $error("bad link status");

	// channel after an accepted non-final item follows in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
		m_tdata[CHAN_W-1:0] == $past(m_tdata[CHAN_W-1:0]) + 1'b1)
		else $error("channel items out of order");

endmodule

bind sbus_frame_decoder_top sfd_checker u_sfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the serial-bus frame decoder
// Streams received bytes into the decoder: a table of directed frames (all
// zeros, all ones, each link status, start bytes as content, bad end byte),
// then random frames mixed with line noise and truncated frames. A predictor
// decodes every accepted byte and queues the expected channel items, which
// are checked field by field against the output stream. Both sides idle at
// random, and once the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
	import sfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam real CLK_PERIOD   = 4.0;
	localparam int  RAND_ITEMS   = 140;
	localparam int  QUIET_ITEMS  = 100;   // past this count, no idling
	localparam int  HOLD_CYCLES  = 400;   // long receiver hold-off
	localparam int  DRAIN_CYCLES = 64;
	localparam int  STALL_LIMIT  = 3000;
	localparam int  DIR_ROWS     = 7;

	// one expected output item
	typedef struct {
		logic [CHAN_W-1:0]  idx;
		logic [VALUE_W-1:0] value;
		link_status_t       status;
		logic               last;
	} chan_item_t;

	// one directed frame; typed rows carry the value and status of every channel
	typedef struct {
		int           lead_n;
		logic [7:0]   lead_b;
		logic [7:0]   fill_even;
		logic [7:0]   fill_odd;
		logic [7:0]   flags;
		logic [7:0]   end_b;
		bit           typed;
		logic [VALUE_W-1:0] tv;
		link_status_t ts;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;   // [7:0] rx_byte
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [3:0] channel_index, [14:4] channel_value,
	                                   // [16:15] link_status, rest zero
	logic                   m_tlast;   // last

	chan_item_t pending_channels[$];
	chan_item_t want;
	dir_row_t   dir_rows [DIR_ROWS];
	logic [7:0] frame_buf [DATA_BYTES];

	// predictor state
	logic [7:0]       rx_store [STORED_BYTES];
	logic [POS_W-1:0] rx_pos;
	bit               rx_framing;

	bit tx_gaps_on;
	bit rx_gaps_on;
	bit hold_req;
	int fail_count;
	int stall_cycles;
	int rand_items;

	sbus_frame_decoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decode one accepted byte; a good end byte queues all channel items
	task automatic decode_rx_byte(input logic [7:0] b, input bit typed,
			input logic [VALUE_W-1:0] tv, input link_status_t ts);
		logic [DATA_W-1:0] bits;
		logic [7:0]        flags;
		link_status_t      st;
		chan_item_t        ci;
		int                i;
		if (!rx_framing) begin
			if (b == START_BYTE) begin
				rx_framing = 1'b1;
				rx_pos     = '0;
			end
		end else if (rx_pos < STORED_BYTES) begin
			rx_store[rx_pos] = b;
			rx_pos = rx_pos + 1'b1;
		end else begin
			rx_framing = 1'b0;
			rx_pos     = '0;
			if (b == END_BYTE) begin
				for (i = 0; i < DATA_BYTES; i++) begin
					bits[8*i +: 8] = rx_store[i];
				end
				flags = rx_store[STORED_BYTES-1];
				if (flags[FAILSAFE_BIT]) begin
					st = LINK_FAILSAFE;
				end else if (flags[LOST_BIT]) begin
					st = LINK_LOST;
				end else begin
					st = LINK_OK;
				end
				for (i = 0; i < CHANNELS; i++) begin
					ci.idx    = i[CHAN_W-1:0];
					ci.value  = typed ? tv : bits[i*VALUE_W +: VALUE_W];
					ci.status = typed ? ts : st;
					ci.last   = (i == CHANNELS - 1);
					pending_channels.push_back(ci);
				end
			end
		end
	endtask

	// offer one byte, with an optional idle burst first; valid stays high after
	task automatic send_rx_byte(input logic [7:0] b, input bit typed,
			input logic [VALUE_W-1:0] tv, input link_status_t ts);
		int gap;
		if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		decode_rx_byte(b, typed, tv, ts);
	endtask

	// start byte, frame_buf, flag byte, end byte
	task automatic send_frame(input logic [7:0] flags, input logic [7:0] end_b,
			input bit typed, input logic [VALUE_W-1:0] tv, input link_status_t ts);
		int i;
		send_rx_byte(START_BYTE, typed, tv, ts);
		for (i = 0; i < DATA_BYTES; i++) begin
			send_rx_byte(frame_buf[i], typed, tv, ts);
		end
		send_rx_byte(flags, typed, tv, ts);
		send_rx_byte(end_b, typed, tv, ts);
	endtask

	// data byte biased toward the extremes and the start byte
	function automatic logic [7:0] pick_data_byte();
		int k;
		k = $urandom_range(0, 15);
		if (k < 2) begin
			return 8'h00;
		end else if (k < 4) begin
			return 8'hff;
		end else if (k == 4) begin
			return START_BYTE;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// stimulus and end of run
	initial begin
		int         r;
		int         i;
		int         n;
		int         kind;
		logic [7:0] flags;
		logic [7:0] end_b;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		arst_n     = 1'b0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		// receiver holds off from the first cycle after reset
		hold_req   = 1'b1;
		fail_count = 0;
		rand_items = 0;
		rx_framing = 1'b0;
		rx_pos     = '0;
		for (i = 0; i < STORED_BYTES; i++) begin
			rx_store[i] = '0;
		end

		dir_rows[0] = '{2, 8'hff, 8'h00, 8'h00, 8'h00, END_BYTE, 1'b1, 11'd0, LINK_OK};
		dir_rows[1] = '{0, 8'h00, 8'hff, 8'hff, 8'h08, END_BYTE, 1'b1, 11'd2047,
			LINK_FAILSAFE};
		dir_rows[2] = '{0, 8'h00, 8'h00, 8'h00, 8'h04, END_BYTE, 1'b1, 11'd0, LINK_LOST};
		dir_rows[3] = '{1, 8'h00, 8'hff, 8'hff, 8'h0c, END_BYTE, 1'b1, 11'd2047,
			LINK_FAILSAFE};
		// start bytes as content, flag bits other than lost and failsafe set
		dir_rows[4] = '{1, 8'h0e, START_BYTE, START_BYTE, 8'hf3, END_BYTE, 1'b0, 11'd0,
			LINK_OK};
		// bad end byte: frame dropped
		dir_rows[5] = '{0, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 11'd0, LINK_OK};
		dir_rows[6] = '{1, 8'h10, 8'h55, 8'haa, 8'h00, END_BYTE, 1'b0, 11'd0, LINK_OK};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames; the held-off receiver lets them fill the block
		for (r = 0; r < DIR_ROWS; r++) begin
			for (i = 0; i < dir_rows[r].lead_n; i++) begin
				send_rx_byte(dir_rows[r].lead_b, 1'b0, '0, LINK_OK);
			end
			for (i = 0; i < DATA_BYTES; i++) begin
				frame_buf[i] = i[0] ? dir_rows[r].fill_odd : dir_rows[r].fill_even;
			end
			send_frame(dir_rows[r].flags, dir_rows[r].end_b, dir_rows[r].typed,
				dir_rows[r].tv, dir_rows[r].ts);
		end

		// random frames, noise and broken frames
		while (rand_items < RAND_ITEMS) begin
			if (rand_items >= QUIET_ITEMS) begin
				tx_gaps_on = 1'b0;
				rx_gaps_on = 1'b0;
			end else begin
				tx_gaps_on = ($urandom_range(0, 3) != 0);
				rx_gaps_on = ($urandom_range(0, 3) != 0);
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// line noise while hunting
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) begin
					send_rx_byte(8'($urandom_range(0, 255)), 1'b0, '0, LINK_OK);
				end
				rand_items += n;
			end else if (kind == 1) begin
				// truncated frame; the next frame lands inside it
				n = $urandom_range(1, 10);
				send_rx_byte(START_BYTE, 1'b0, '0, LINK_OK);
				for (i = 0; i < n; i++) begin
					send_rx_byte(pick_data_byte(), 1'b0, '0, LINK_OK);
				end
				rand_items += n + 1;
			end else begin
				for (i = 0; i < DATA_BYTES; i++) begin
					frame_buf[i] = pick_data_byte();
				end
				if ($urandom_range(0, 3) == 0) begin
					flags = 8'($urandom_range(0, 3) << LOST_BIT);
				end else begin
					flags = 8'($urandom_range(0, 255));
				end
				end_b = (kind == 2) ? 8'($urandom_range(1, 255)) : END_BYTE;
				send_frame(flags, end_b, 1'b0, '0, LINK_OK);
				rand_items += DATA_BYTES + 3;
			end
		end
		s_tvalid <= 1'b0;

		while (pending_channels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 10);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// output check against the oldest expected channel item
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_channels.size() == 0) begin
				$error("unexpected item: tdata %h tlast %b", m_tdata, m_tlast);
				fail_count++;
			end else begin
				want = pending_channels.pop_front();
				if (m_tdata[CHAN_W-1:0] !== want.idx) begin
					$error("channel_index: expected %0d, got %0d", want.idx,
						m_tdata[CHAN_W-1:0]);
					fail_count++;
				end
				if (m_tdata[CHAN_W +: VALUE_W] !== want.value) begin
					$error("channel_value: expected %0d, got %0d", want.value,
						m_tdata[CHAN_W +: VALUE_W]);
					fail_count++;
				end
				if (m_tdata[CHAN_W+VALUE_W +: 2] !== want.status) begin
					$error("link_status: expected %0d, got %0d", want.status,
						m_tdata[CHAN_W+VALUE_W +: 2]);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
				if (m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0) begin
					$error("tdata padding: expected 0, got %h",
						m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
